// ----- src/bss_pkg.sv -----
package bss_pkg;

  typedef enum logic [1:0] {
    MK_AUTO     = 2'd0,
    MK_PLAIN    = 2'd1,
    MK_ENHANCED = 2'd2,
    MK_EXTENDED = 2'd3
  } machine_t;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_MAIN = 2'd1,
    TGT_AUX  = 2'd2
  } target_t;

  localparam int unsigned FLAG_W = 14;

  localparam int unsigned FLG_TEXT    = 0;
  localparam int unsigned FLG_MIX     = 1;
  localparam int unsigned FLG_PAGE2   = 2;
  localparam int unsigned FLG_HIRES   = 3;
  localparam int unsigned FLG_STORE80 = 4;
  localparam int unsigned FLG_AUXWR   = 5;
  localparam int unsigned FLG_AUXZP   = 6;
  localparam int unsigned FLG_COL80   = 7;
  localparam int unsigned FLG_ALTCHAR = 8;
  localparam int unsigned FLG_MONO    = 9;
  localparam int unsigned FLG_DGR     = 10;
  localparam int unsigned FLG_IOUDIS  = 11;
  localparam int unsigned FLG_IIE     = 12;
  localparam int unsigned FLG_IIGS    = 13;

  // config register indexes
  localparam logic CFG_START_MODE = 1'b0;
  localparam logic CFG_LINEAR_MIR = 1'b1;

  // io page 0xc000-0xc07f
  localparam logic [8:0] IO_PAGE = 9'h180;

  localparam logic [6:0] OFF_STORE80_OFF = 7'h00;
  localparam logic [6:0] OFF_STORE80_ON  = 7'h01;
  localparam logic [6:0] OFF_AUXWR_OFF   = 7'h04;
  localparam logic [6:0] OFF_AUXWR_ON    = 7'h05;
  localparam logic [6:0] OFF_AUXZP_OFF   = 7'h08;
  localparam logic [6:0] OFF_AUXZP_ON    = 7'h09;
  localparam logic [6:0] OFF_COL80_OFF   = 7'h0c;
  localparam logic [6:0] OFF_COL80_ON    = 7'h0d;
  localparam logic [6:0] OFF_ALTCHAR_OFF = 7'h0e;
  localparam logic [6:0] OFF_ALTCHAR_ON  = 7'h0f;
  localparam logic [6:0] OFF_MONO        = 7'h21;
  localparam logic [6:0] OFF_TEXTCOL     = 7'h22;
  localparam logic [6:0] OFF_NEWVIDEO    = 7'h29;
  localparam logic [6:0] OFF_BORDER      = 7'h34;
  localparam logic [6:0] OFF_SHADOW      = 7'h35;
  localparam logic [6:0] OFF_DGR_ON      = 7'h5e;
  localparam logic [6:0] OFF_DGR_OFF     = 7'h5f;
  localparam logic [6:0] OFF_IOUDIS_ON   = 7'h7e;
  localparam logic [6:0] OFF_IOUDIS_OFF  = 7'h7f;
  // offsets 0x50-0x57: text, mix, page2, hires
  localparam logic [3:0] VIDEO_GROUP     = 4'ha;

  localparam logic [31:0] KEY_EXTENDED = 32'hC0330100;
  localparam logic [31:0] KEY_PLAIN    = 32'h01F901FB;
  localparam logic [31:0] KEY_ENHANCED = 32'h01F5018B;

  localparam logic [15:0] RAM_LO    = 16'h0200;
  localparam logic [15:0] RAM_END   = 16'hC000;
  localparam logic [15:0] HIRES_LO  = 16'h2000;
  localparam logic [15:0] HIRES_END = 16'h4000;
  localparam logic [15:0] TEXT_LO   = 16'h0400;
  localparam logic [15:0] TEXT_END  = 16'h0800;

  typedef struct packed {
    logic [15:0] address;
    logic [7:0]  data;
    logic [1:0]  side;
    logic        is_write;
  } bss_item_t;

  typedef struct packed {
    logic [FLAG_W-1:0] flags;
    logic [7:0]        newvideo;
    logic [7:0]        shadow;
    machine_t          machine;
    logic              fp_done;
    logic [3:0]        border;
    logic [7:0]        textcol;
  } bss_state_t;

  typedef struct packed {
    target_t     target;
    logic [15:0] address;
    logic [7:0]  data;
  } bss_result_t;

endpackage

// ----- src/bus_snoop_softswitch_shadow_core.sv -----
// Soft-switch bus snooper.
// s_* channel: one host bus cycle per word. The receiver sees every cycle in
// bus order; reads only move flags, writes may also be shadowed.
// m_* channel: one result word per bus cycle, carrying the shadow write
// (target, address, data) and the full video state after that cycle.
// cfg_*: register writes, taken whenever cfg_we is high; index 0 is the
// start mode (reloads machine type, iie/iigs flags, clears the fingerprint),
// index 1 the linear mirror enable. Write only while no word is in flight.
// Path: input register, then decode and result register. Throughput: one
// word per cycle while m_tready is high, set by the state update loop in
// the decode stage.
// Reset: synchronous rst empties both stages and clears all state; the
// machine type comes back as auto and the flags as zero.
// Stall: while m_tready is low the result word holds, one more word waits
// in the input register, and s_tready drops once both are full.
module bus_snoop_softswitch_shadow_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // bus_address, bus_data, side_bits, zero pad
  input  logic        s_tuser,   // is_write
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // write_address, write_data, mode_flags,
                                 // newvideo_bits, shadow_bits, machine_kind,
                                 // border_colour, text_colours, zero pad
  output logic [1:0]  m_tuser,   // write_target
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data
);
  import bss_pkg::*;

  bss_item_t   s1_item;
  logic        s1_valid;
  logic        adv;
  bss_state_t  state;
  bss_state_t  state_next;
  bss_state_t  dec_state;
  bss_result_t dec_res;
  bss_result_t out_res;
  bss_state_t  out_state;
  logic        linear_mirror;

  assign adv      = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_item.address  <= s_tdata[15:0];
      s1_item.data     <= s_tdata[23:16];
      s1_item.side     <= s_tdata[25:24];
      s1_item.is_write <= s_tuser;
    end
  end

  bss_decode u_decode (
    .item          (s1_item),
    .cur           (state),
    .linear_mirror (linear_mirror),
    .nxt           (dec_state),
    .res           (dec_res)
  );

  always_comb begin
    state_next = state;
    if (cfg_we && cfg_index == CFG_START_MODE) begin
      state_next.machine        = machine_t'(cfg_data);
      state_next.flags[FLG_IIE]  = cfg_data == MK_ENHANCED;
      state_next.flags[FLG_IIGS] = cfg_data == MK_EXTENDED;
      state_next.fp_done        = 1'b0;
    end else if (adv) begin
      state_next = dec_state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= '0;
      linear_mirror <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we && cfg_index == CFG_LINEAR_MIR) begin
        linear_mirror <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res   <= dec_res;
      out_state <= dec_state;
    end
  end

  assign m_tuser = out_res.target;
  assign m_tdata = {4'b0, out_state.textcol, out_state.border, out_state.machine,
                    out_state.shadow, out_state.newvideo, out_state.flags,
                    out_res.data, out_res.address};

`ifndef NO_ASSERTIONS
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == TGT_NONE |-> m_tdata[23:0] == 24'h0)
    else $error("shadow address or data set with no target");

  a_write_in_ram: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != TGT_NONE |->
      m_tdata[15:0] >= RAM_LO && m_tdata[15:0] < RAM_END)
    else $error("shadow write outside ram window");

  a_one_regset: assert property (@(posedge clk) disable iff (rst)
    !(state.flags[FLG_IIE] && state.flags[FLG_IIGS]))
    else $error("iie and iigs register sets both active");

  a_fp_machine: assert property (@(posedge clk) disable iff (rst)
    state.fp_done |-> state.machine != MK_AUTO)
    else $error("fingerprint done with machine still auto");
`endif

endmodule

// ----- src/bss_decode.sv -----
module bss_decode (
  input  bss_pkg::bss_item_t   item,
  input  bss_pkg::bss_state_t  cur,
  input  logic                 linear_mirror,
  output bss_pkg::bss_state_t  nxt,
  output bss_pkg::bss_result_t res
);
  import bss_pkg::*;

  logic        io_hit;
  logic [6:0]  off;
  logic        consumed;
  logic        ext;
  logic        gs;
  logic        e2;
  logic        wr;
  logic [3:0]  vid;
  logic [31:0] key;
  logic        in_ram;
  logic        in_hi;
  logic        in_text;
  logic        in_lin;
  target_t     tgt;

  assign io_hit  = item.address[15:7] == IO_PAGE;
  assign off     = item.address[6:0];
  assign ext     = cur.flags[FLG_IIE] | cur.flags[FLG_IIGS];
  assign gs      = cur.flags[FLG_IIGS];
  assign e2      = cur.flags[FLG_IIE];
  assign wr      = item.is_write;
  assign key     = {item.address, 6'b0, item.side, item.data};
  assign in_ram  = (item.address >= RAM_LO) && (item.address < RAM_END);
  assign in_lin  = (item.address >= HIRES_LO) && (item.address < RAM_END);
  assign in_hi   = (item.address >= HIRES_LO) && (item.address < HIRES_END);
  assign in_text = (item.address >= TEXT_LO) && (item.address < TEXT_END);

  always_comb begin
    nxt      = cur;
    consumed = 1'b0;
    vid      = cur.flags[3:0];
    tgt      = TGT_NONE;
    if (io_hit) begin
      consumed = 1'b1;
      if (off[6:3] == VIDEO_GROUP) begin
        vid[off[2:1]] = off[0];
        nxt.flags[3:0] = vid;
      end else begin
        unique case (off)
          OFF_STORE80_OFF, OFF_STORE80_ON: begin
            if (ext && wr) nxt.flags[FLG_STORE80] = off[0];
          end
          OFF_AUXWR_OFF, OFF_AUXWR_ON: begin
            if (ext && wr) nxt.flags[FLG_AUXWR] = off[0];
          end
          OFF_AUXZP_OFF, OFF_AUXZP_ON: begin
            if (ext && wr) nxt.flags[FLG_AUXZP] = off[0];
          end
          OFF_COL80_OFF, OFF_COL80_ON: begin
            if (ext && wr) nxt.flags[FLG_COL80] = off[0];
          end
          OFF_ALTCHAR_OFF, OFF_ALTCHAR_ON: begin
            if (ext && wr) nxt.flags[FLG_ALTCHAR] = off[0];
          end
          OFF_MONO: begin
            if (gs && wr) nxt.flags[FLG_MONO] = item.data[7];
          end
          OFF_TEXTCOL: begin
            if (gs && wr) nxt.textcol = item.data;
          end
          OFF_NEWVIDEO: begin
            if (gs && wr) nxt.newvideo = item.data;
          end
          OFF_BORDER: begin
            if (gs && wr) nxt.border = item.data[3:0];
          end
          OFF_SHADOW: begin
            if (gs && wr) nxt.shadow = item.data;
          end
          OFF_DGR_ON: begin
            if (ext) nxt.flags[FLG_DGR] = 1'b1;
          end
          OFF_DGR_OFF: begin
            if (ext) nxt.flags[FLG_DGR] = 1'b0;
          end
          OFF_IOUDIS_ON: begin
            if (e2 && wr) nxt.flags[FLG_IOUDIS] = 1'b1;
          end
          OFF_IOUDIS_OFF: begin
            if (e2 && wr) nxt.flags[FLG_IOUDIS] = 1'b0;
          end
          default: begin
            consumed = 1'b0;
          end
        endcase
      end
    end

    if (!consumed && wr) begin
      // machine fingerprint, auto mode only
      if (cur.machine == MK_AUTO && !cur.fp_done) begin
        priority if (key == KEY_EXTENDED) begin
          nxt.machine         = MK_EXTENDED;
          nxt.flags[FLG_IIE]  = 1'b0;
          nxt.flags[FLG_IIGS] = 1'b1;
          nxt.fp_done         = 1'b1;
        end else if (key == KEY_PLAIN) begin
          nxt.machine         = MK_PLAIN;
          nxt.flags[FLG_IIE]  = 1'b0;
          nxt.flags[FLG_IIGS] = 1'b0;
          nxt.fp_done         = 1'b1;
        end else if (key == KEY_ENHANCED) begin
          nxt.machine         = MK_ENHANCED;
          nxt.flags[FLG_IIE]  = 1'b1;
          nxt.flags[FLG_IIGS] = 1'b0;
          nxt.fp_done         = 1'b1;
        end else begin
          nxt.machine = cur.machine;
        end
      end

      // shadow routing
      priority if (linear_mirror && in_lin) begin
        tgt = TGT_AUX;
      end else if (cur.flags[FLG_STORE80] && cur.flags[FLG_PAGE2] && in_text) begin
        tgt = TGT_AUX;
      end else if (cur.flags[FLG_STORE80] && cur.flags[FLG_PAGE2] &&
                   cur.flags[FLG_HIRES] && in_hi) begin
        tgt = TGT_AUX;
      end else if (!cur.flags[FLG_STORE80] && cur.flags[FLG_AUXWR] && in_ram) begin
        tgt = TGT_AUX;
      end else if (in_ram) begin
        tgt = TGT_MAIN;
      end else begin
        tgt = TGT_NONE;
      end
    end
  end

  always_comb begin
    res.target  = tgt;
    res.address = (tgt == TGT_NONE) ? 16'h0 : item.address;
    res.data    = (tgt == TGT_NONE) ? 8'h0 : item.data;
  end

endmodule

// ----- verif/tb_bus_snoop_softswitch_shadow_core.sv -----
module tb_bus_snoop_softswitch_shadow_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bss_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 103;

  typedef struct packed {
    target_t           target;
    logic [15:0]       waddr;
    logic [7:0]        wdata;
    logic [FLAG_W-1:0] flags;
    logic [7:0]        newvideo;
    logic [7:0]        shadow;
    machine_t          machine;
    logic [3:0]        border;
    logic [7:0]        textcol;
  } snoop_word_t;

  class softswitch_scoreboard;
    logic [FLAG_W-1:0] flags;
    logic [7:0]        newvideo;
    logic [7:0]        shadow;
    logic [7:0]        textcol;
    logic [3:0]        border;
    machine_t          machine;
    bit                fp_done;
    logic [1:0]        start_mode;
    bit                mirror;
    snoop_word_t       pending_results[$];
    int                mismatches;
    int                shadow_writes;
    int                aux_writes;
    int                fingerprints;

    function new();
      flags = '0;
      newvideo = '0;
      shadow = '0;
      textcol = '0;
      border = '0;
      start_mode = '0;
      mirror = 0;
      mismatches = 0;
      shadow_writes = 0;
      aux_writes = 0;
      fingerprints = 0;
      load_machine(MK_AUTO);
    endfunction

    function void load_machine(machine_t kind);
      machine = kind;
      flags[FLG_IIE] = (kind == MK_ENHANCED);
      flags[FLG_IIGS] = (kind == MK_EXTENDED);
      fp_done = 0;
    endfunction

    function void write_register(logic idx, logic [1:0] val);
      if (idx == CFG_START_MODE) begin
        start_mode = val;
        load_machine(machine_t'(val));
      end else begin
        mirror = val[0];
      end
    endfunction

    function bit decode_switch(logic [6:0] off, logic [7:0] data, bit wr);
      bit ext;
      bit gs;
      bit e;
      bit paired;
      int unsigned idx;
      ext = flags[FLG_IIE] | flags[FLG_IIGS];
      gs = flags[FLG_IIGS];
      e = flags[FLG_IIE];
      paired = 0;
      idx = 0;
      if (off[6:3] == VIDEO_GROUP) begin
        flags[FLG_TEXT + off[2:1]] = off[0];
        return 1'b1;
      end
      case (off)
        OFF_STORE80_OFF, OFF_STORE80_ON: begin
          paired = 1;
          idx = FLG_STORE80;
        end
        OFF_AUXWR_OFF, OFF_AUXWR_ON: begin
          paired = 1;
          idx = FLG_AUXWR;
        end
        OFF_AUXZP_OFF, OFF_AUXZP_ON: begin
          paired = 1;
          idx = FLG_AUXZP;
        end
        OFF_COL80_OFF, OFF_COL80_ON: begin
          paired = 1;
          idx = FLG_COL80;
        end
        OFF_ALTCHAR_OFF, OFF_ALTCHAR_ON: begin
          paired = 1;
          idx = FLG_ALTCHAR;
        end
        OFF_MONO: if (gs && wr) flags[FLG_MONO] = data[7];
        OFF_TEXTCOL: if (gs && wr) textcol = data;
        OFF_NEWVIDEO: if (gs && wr) newvideo = data;
        OFF_BORDER: if (gs && wr) border = data[3:0];
        OFF_SHADOW: if (gs && wr) shadow = data;
        OFF_DGR_ON: if (ext) flags[FLG_DGR] = 1'b1;
        OFF_DGR_OFF: if (ext) flags[FLG_DGR] = 1'b0;
        OFF_IOUDIS_ON: if (e && wr) flags[FLG_IOUDIS] = 1'b1;
        OFF_IOUDIS_OFF: if (e && wr) flags[FLG_IOUDIS] = 1'b0;
        default: return 1'b0;
      endcase
      if (paired && ext && wr) flags[idx] = off[0];
      return 1'b1;
    endfunction

    function void take_fingerprint(bss_item_t c);
      logic [31:0] key;
      key = {c.address, 6'b0, c.side, c.data};
      if (machine != MK_AUTO || fp_done) return;
      if (key == KEY_EXTENDED) begin
        machine = MK_EXTENDED;
        flags[FLG_IIE] = 1'b0;
        flags[FLG_IIGS] = 1'b1;
        fp_done = 1;
      end else if (key == KEY_PLAIN) begin
        machine = MK_PLAIN;
        flags[FLG_IIE] = 1'b0;
        flags[FLG_IIGS] = 1'b0;
        fp_done = 1;
      end else if (key == KEY_ENHANCED) begin
        machine = MK_ENHANCED;
        flags[FLG_IIE] = 1'b1;
        flags[FLG_IIGS] = 1'b0;
        fp_done = 1;
      end
      if (fp_done) fingerprints++;
    endfunction

    function target_t route(logic [15:0] a);
      bit ram;
      ram = (a >= RAM_LO) && (a < RAM_END);
      if (mirror && a >= HIRES_LO && a < RAM_END) return TGT_AUX;
      if (flags[FLG_STORE80]) begin
        if (flags[FLG_PAGE2]) begin
          if (a >= TEXT_LO && a < TEXT_END) return TGT_AUX;
          if (flags[FLG_HIRES] && a >= HIRES_LO && a < HIRES_END) return TGT_AUX;
        end
      end else if (flags[FLG_AUXWR] && ram) begin
        return TGT_AUX;
      end
      if (ram) return TGT_MAIN;
      return TGT_NONE;
    endfunction

    function void note_bus_cycle(bss_item_t c);
      snoop_word_t w;
      bit consumed;
      consumed = 0;
      w.target = TGT_NONE;
      if (c.address[15:7] == IO_PAGE)
        consumed = decode_switch(c.address[6:0], c.data, c.is_write);
      if (!consumed && c.is_write) begin
        take_fingerprint(c);
        w.target = route(c.address);
      end
      w.waddr = (w.target != TGT_NONE) ? c.address : 16'h0000;
      w.wdata = (w.target != TGT_NONE) ? c.data : 8'h00;
      w.flags = flags;
      w.newvideo = newvideo;
      w.shadow = shadow;
      w.machine = machine;
      w.border = border;
      w.textcol = textcol;
      if (w.target != TGT_NONE) shadow_writes++;
      if (w.target == TGT_AUX) aux_writes++;
      pending_results.push_back(w);
    endfunction

    function string show(snoop_word_t w);
      return $sformatf("tgt=%0d addr=%h data=%h flags=%h nv=%h shd=%h mach=%0d bord=%h tc=%h",
                       w.target, w.waddr, w.wdata, w.flags, w.newvideo, w.shadow,
                       w.machine, w.border, w.textcol);
    endfunction

    function void check_result(logic [1:0] tuser, logic [71:0] tdata);
      snoop_word_t got;
      snoop_word_t want;
      got.target = target_t'(tuser);
      got.waddr = tdata[15:0];
      got.wdata = tdata[23:16];
      got.flags = tdata[37:24];
      got.newvideo = tdata[45:38];
      got.shadow = tdata[53:46];
      got.machine = machine_t'(tdata[55:54]);
      got.border = tdata[59:56];
      got.textcol = tdata[67:60];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %s", show(got));
        return;
      end
      want = pending_results.pop_front();
      if (got.target !== want.target || got.waddr !== want.waddr ||
          got.wdata !== want.wdata || got.flags !== want.flags ||
          got.newvideo !== want.newvideo || got.shadow !== want.shadow ||
          got.machine !== want.machine || got.border !== want.border ||
          got.textcol !== want.textcol) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t", $realtime);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [1:0]  cfg_data = '0;

  softswitch_scoreboard sb;
  bit          no_gaps = 0;
  int          cycle_count = 0;
  int          cycles_sent = 0;
  int          mode_settings = 0;
  logic [6:0]  switch_offs [19];

  bus_snoop_softswitch_shadow_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_bus_snoop_softswitch_shadow_core NOT OK");
      $finish;
    end
  end

  // result side
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    m_tready <= no_gaps || ($urandom_range(0, 99) >= 25);
  end

  task automatic send_cycle(input bss_item_t c);
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < 25) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, c.side, c.data, c.address};
    s_tuser <= c.is_write;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_bus_cycle(c);
    cycles_sent++;
  endtask

  task automatic drive_cycle(input logic [15:0] a, input logic [7:0] d,
                             input logic [1:0] s, input logic w);
    bss_item_t c;
    c.address = a;
    c.data = d;
    c.side = s;
    c.is_write = w;
    send_cycle(c);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] sm, input logic mir);
    cfg_we <= 1'b1;
    cfg_index <= CFG_START_MODE;
    cfg_data <= sm;
    @(posedge clk);
    sb.write_register(CFG_START_MODE, sm);
    cfg_index <= CFG_LINEAR_MIR;
    cfg_data <= {1'b0, mir};
    @(posedge clk);
    sb.write_register(CFG_LINEAR_MIR, {1'b0, mir});
    cfg_we <= 1'b0;
    mode_settings++;
  endtask

  function automatic bss_item_t random_cycle();
    bss_item_t c;
    int unsigned r;
    int unsigned sub;
    logic [31:0] key;
    r = $urandom_range(0, 99);
    c.data = 8'($urandom);
    c.side = 2'($urandom);
    c.is_write = ($urandom_range(0, 99) < 70);
    if (r < 35) begin
      sub = $urandom_range(0, 99);
      if (sub < 50) c.address = {IO_PAGE, switch_offs[$urandom_range(0, 18)]};
      else if (sub < 80) c.address = {IO_PAGE, VIDEO_GROUP, 3'($urandom)};
      else c.address = {IO_PAGE, 7'($urandom)};
    end else if (r < 75) begin
      sub = $urandom_range(0, 2);
      if (sub == 0) c.address = TEXT_LO + 16'($urandom_range(0, 16'h3ff));
      else if (sub == 1) c.address = HIRES_LO + 16'($urandom_range(0, 16'h1fff));
      else c.address = 16'($urandom_range(RAM_LO, RAM_END - 1));
    end else if (r < 80) begin
      sub = $urandom_range(0, 2);
      key = (sub == 0) ? KEY_EXTENDED : (sub == 1) ? KEY_PLAIN : KEY_ENHANCED;
      c.address = key[31:16];
      c.side = key[9:8];
      c.data = key[7:0];
      c.is_write = 1'b1;
    end else begin
      c.address = 16'($urandom);
    end
    return c;
  endfunction

  initial begin
    logic [1:0] phase_mode [PHASES];
    logic       phase_mirror [PHASES];
    sb = new();
    switch_offs = '{OFF_STORE80_OFF, OFF_STORE80_ON, OFF_AUXWR_OFF, OFF_AUXWR_ON,
                    OFF_AUXZP_OFF, OFF_AUXZP_ON, OFF_COL80_OFF, OFF_COL80_ON,
                    OFF_ALTCHAR_OFF, OFF_ALTCHAR_ON, OFF_MONO, OFF_TEXTCOL,
                    OFF_NEWVIDEO, OFF_BORDER, OFF_SHADOW, OFF_DGR_ON, OFF_DGR_OFF,
                    OFF_IOUDIS_ON, OFF_IOUDIS_OFF};
    phase_mode = '{MK_AUTO, MK_EXTENDED, MK_ENHANCED, MK_PLAIN,
                   MK_AUTO, MK_EXTENDED, MK_ENHANCED, MK_AUTO};
    phase_mirror = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // auto mode: fingerprint misses, then extended machine
    drive_cycle(KEY_EXTENDED[31:16], KEY_EXTENDED[7:0], KEY_EXTENDED[9:8], 1'b0);
    drive_cycle(KEY_EXTENDED[31:16], KEY_EXTENDED[7:0], 2'd0, 1'b1);
    drive_cycle({IO_PAGE, OFF_STORE80_ON}, 8'hff, 2'd3, 1'b1);
    drive_cycle(KEY_EXTENDED[31:16], KEY_EXTENDED[7:0], KEY_EXTENDED[9:8], 1'b1);
    drive_cycle({IO_PAGE, OFF_MONO}, 8'h80, 2'd0, 1'b1);
    drive_cycle({IO_PAGE, OFF_TEXTCOL}, 8'ha5, 2'd0, 1'b1);
    drive_cycle({IO_PAGE, OFF_NEWVIDEO}, 8'hff, 2'd3, 1'b1);
    drive_cycle({IO_PAGE, OFF_BORDER}, 8'hff, 2'd0, 1'b1);
    drive_cycle({IO_PAGE, OFF_SHADOW}, 8'h5a, 2'd0, 1'b1);
    drive_cycle({IO_PAGE, OFF_SHADOW}, 8'h00, 2'd0, 1'b0);
    drive_cycle({IO_PAGE, VIDEO_GROUP, 3'd1}, 8'h00, 2'd0, 1'b0);
    drive_cycle({IO_PAGE, VIDEO_GROUP, 3'd7}, 8'h00, 2'd0, 1'b0);
    drive_cycle({IO_PAGE, VIDEO_GROUP, 3'd5}, 8'h00, 2'd0, 1'b1);
    drive_cycle({IO_PAGE, OFF_STORE80_ON}, 8'h00, 2'd0, 1'b1);
    drive_cycle({IO_PAGE, OFF_AUXWR_ON}, 8'h00, 2'd0, 1'b1);
    drive_cycle(TEXT_LO, 8'h00, 2'd0, 1'b1);
    drive_cycle(HIRES_LO, 8'hff, 2'd3, 1'b1);
    drive_cycle(RAM_LO, 8'h3c, 2'd1, 1'b1);
    drive_cycle(RAM_END - 16'd1, 8'hc3, 2'd2, 1'b1);
    drive_cycle(16'hffff, 8'hff, 2'd3, 1'b1);
    drive_cycle(16'h0000, 8'h00, 2'd0, 1'b1);
    drive_cycle({IO_PAGE, OFF_DGR_ON}, 8'h00, 2'd0, 1'b0);
    drive_cycle({IO_PAGE, OFF_IOUDIS_ON}, 8'h00, 2'd0, 1'b1);
    drive_cycle({IO_PAGE, OFF_STORE80_OFF}, 8'h00, 2'd0, 1'b1);
    drive_cycle(16'h1000, 8'h77, 2'd0, 1'b1);
    drive_cycle(KEY_PLAIN[31:16], KEY_PLAIN[7:0], KEY_PLAIN[9:8], 1'b1);

    // plain and enhanced fingerprints after a fresh auto start
    drain();
    set_mode(MK_AUTO, 1'b0);
    drive_cycle(KEY_PLAIN[31:16], KEY_PLAIN[7:0], KEY_PLAIN[9:8], 1'b1);
    drive_cycle({IO_PAGE, OFF_STORE80_ON}, 8'h00, 2'd0, 1'b1);
    drain();
    set_mode(MK_AUTO, 1'b0);
    drive_cycle(KEY_ENHANCED[31:16], KEY_ENHANCED[7:0], KEY_ENHANCED[9:8], 1'b1);
    drive_cycle({IO_PAGE, OFF_IOUDIS_ON}, 8'h00, 2'd0, 1'b1);
    drive_cycle({IO_PAGE, OFF_MONO}, 8'h80, 2'd0, 1'b1);
    drive_cycle({IO_PAGE, OFF_IOUDIS_OFF}, 8'h00, 2'd0, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      set_mode(phase_mode[p], phase_mirror[p]);
      no_gaps = (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 0 && i == 50) drain();
        send_cycle(random_cycle());
      end
    end
    no_gaps = 0;

    drain();
    repeat (8) @(posedge clk);
    if (sb.pending_results.size() != 0)
      $display("%0d results never arrived", sb.pending_results.size());
    $display("%0d bus cycles across %0d mode settings; %0d shadow writes (%0d aux), %0d fingerprints",
             cycles_sent, mode_settings, sb.shadow_writes, sb.aux_writes, sb.fingerprints);
    $display("%0d mismatching words", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("tb_bus_snoop_softswitch_shadow_core OK");
    end else begin
      $display("tb_bus_snoop_softswitch_shadow_core NOT OK");
    end
    $finish;
  end

endmodule
